/* rtl/osmp_pkg.sv */
package osmp_pkg;

  localparam int MAX_PREFIX_CHARS_DEF  = 8;
  localparam int MAX_SOURCE_NUMBER_DEF = 64;

  typedef enum logic [8:0] {
    PH_PREFIX = 9'b0_0000_0001,
    PH_TAIL   = 9'b0_0000_0010,
    PH_INDEX  = 9'b0_0000_0100,
    PH_LEAF   = 9'b0_0000_1000,
    PH_APAD   = 9'b0_0001_0000,
    PH_TAG    = 9'b0_0010_0000,
    PH_TPAD   = 9'b0_0100_0000,
    PH_ARG    = 9'b0_1000_0000,
    PH_DONE   = 9'b1_0000_0000
  } phase_t;

  localparam logic [0:0] CFG_PREFIX_BYTES  = 1'b0;
  localparam logic [0:0] CFG_PREFIX_LENGTH = 1'b1;

  localparam logic [1:0] TL_NONE = 2'd0;
  localparam logic [1:0] TL_F    = 2'd1;
  localparam logic [1:0] TL_I    = 2'd2;

  localparam int TAIL_WORDS  = 7;
  localparam int LEAF_WORDS  = 4;
  localparam int SOURCE_WORD = 6;

  localparam logic [8*14-1:0] KW_ACTIVE = {"active_", "sources"};

  typedef logic [7:0] char_t;

  function automatic char_t tail_char(input int unsigned k, input logic [3:0] pos);
    logic [8*14-1:0] s;
    int unsigned len;
    begin
      case (k)
        0: begin s = {"linked", 64'h0};         len = 6;  end
        1: begin s = KW_ACTIVE;                 len = 14; end
        2: begin s = {"azimuth", 56'h0};        len = 7;  end
        3: begin s = {"elevation", 40'h0};      len = 9;  end
        4: begin s = {"width", 72'h0};          len = 5;  end
        5: begin s = {"size", 80'h0};           len = 4;  end
        default: begin s = {"source/", 56'h0};  len = 7;  end
      endcase
      if (32'(pos) >= len) tail_char = 8'h00;
      else tail_char = s[8*(13 - 32'(pos)) +: 8];
    end
  endfunction

  function automatic logic [3:0] tail_len(input int unsigned k);
    case (k)
      0: tail_len = 4'd6;
      1: tail_len = 4'd14;
      2: tail_len = 4'd7;
      3: tail_len = 4'd9;
      4: tail_len = 4'd5;
      5: tail_len = 4'd4;
      default: tail_len = 4'd7;
    endcase
  endfunction

  function automatic char_t leaf_char(input int unsigned k, input logic [3:0] pos);
    logic [8*9-1:0] s;
    int unsigned len;
    begin
      case (k)
        0: begin s = {"azimuth", 16'h0};   len = 7; end
        1: begin s = "elevation";          len = 9; end
        2: begin s = {"size", 40'h0};      len = 4; end
        default: begin s = {"meter", 32'h0}; len = 5; end
      endcase
      if (32'(pos) >= len) leaf_char = 8'h00;
      else leaf_char = s[8*(8 - 32'(pos)) +: 8];
    end
  endfunction

  function automatic logic [3:0] leaf_len(input int unsigned k);
    case (k)
      0: leaf_len = 4'd7;
      1: leaf_len = 4'd9;
      2: leaf_len = 4'd4;
      default: leaf_len = 4'd5;
    endcase
  endfunction

endpackage

/* rtl/osmp_stream_if.sv */
interface osmp_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/osc_source_message_parser_unit.sv */
// Channel | beat payload                        | accepted when
// in_     | data_byte[7:0], last_byte           | in_valid && in_ready
// out_    | accepted, parameter_code, source_number, value_bits | out_valid && out_ready
// cfg_    | index (0 prefix_bytes, 1 prefix_length), wdata[63:0] | cfg_valid && cfg_ready
// One byte is taken each cycle while in_ready is high; the parse state updates in the same cycle.
// The result register is loaded at the edge that takes a last byte, so the result
// appears in the cycle after; the output is a single register, and in_ready stays high
// unless that register is full and stalled.
// rst_n is synchronous and active low; configuration resets to zero.
module osc_source_message_parser_unit #(
  parameter int MAX_PREFIX_CHARS  = osmp_pkg::MAX_PREFIX_CHARS_DEF,
  parameter int MAX_SOURCE_NUMBER = osmp_pkg::MAX_SOURCE_NUMBER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [3:0]  out_parameter_code,
  output logic [6:0]  out_source_number,
  output logic [31:0] out_value_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata
);
  import osmp_pkg::*;

  localparam logic [7:0] SAT = 8'(MAX_SOURCE_NUMBER + 1);
  localparam logic [7:0] MAXS = 8'(MAX_SOURCE_NUMBER);
  localparam logic [3:0] MAXP = 4'(MAX_PREFIX_CHARS);

  logic [63:0] prefix_r;
  logic [3:0]  plen_r;
  phase_t      ph_r, ph_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [6:0]  cand_r, cand_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic        dig_r, dig_nxt;
  logic [1:0]  tl_r, tl_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic        fail_r, fail_nxt;
  logic [1:0]  align_r, align_nxt;
  logic [3:0]  code_r, code_nxt;
  logic        ov_r;
  logic        oa_r;
  logic [3:0]  oc_r;
  logic [6:0]  os_r;
  logic [31:0] ovb_r;
  logic [31:0] conv;
  logic        take, last, ok;
  logic [3:0]  plen;
  logic [10:0] idx_mul;
  logic        adv;
  logic        found;
  logic [3:0]  k_found;
  logic [7:0]  b;

  assign cfg_ready = 1'b1;
  assign in_ready  = !ov_r || out_ready;
  assign take      = in_valid && in_ready;
  assign b         = in_data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 64'd0;
      plen_r   <= 4'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PREFIX_BYTES:  prefix_r <= cfg_wdata;
        CFG_PREFIX_LENGTH: plen_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign plen = (plen_r > MAXP) ? MAXP : plen_r;

  always_comb begin
    ph_nxt = ph_r; cnt_nxt = cnt_r; cand_nxt = cand_r; idx_nxt = idx_r;
    dig_nxt = dig_r; tl_nxt = tl_r; arg_nxt = arg_r; fail_nxt = fail_r;
    align_nxt = align_r; code_nxt = code_r;
    adv = 1'b1; found = 1'b0; k_found = 4'd0; idx_mul = 11'd0;
    if (!fail_r) begin
      if (ph_nxt == PH_PREFIX && cnt_nxt >= plen) begin
        ph_nxt = PH_TAIL; cnt_nxt = 4'd0; cand_nxt = 7'h7F;
      end
      case (ph_nxt)
        PH_PREFIX: begin
          if (b != prefix_r[8*(7 - 32'(cnt_nxt[2:0])) +: 8]) begin
            fail_nxt = 1'b1; adv = 1'b0;
          end else if (cnt_nxt != 4'd15) cnt_nxt = cnt_nxt + 4'd1;
        end
        PH_TAIL: begin
          if (b == 8'd0) begin
            for (int k = SOURCE_WORD - 1; k >= 0; k--) begin
              if (cand_nxt[k] && tail_len(k) == cnt_nxt) begin
                found = 1'b1; k_found = 4'(k);
              end
            end
            if (!found) begin
              fail_nxt = 1'b1; adv = 1'b0;
            end else begin
              code_nxt = k_found; idx_nxt = 8'd0; ph_nxt = PH_APAD;
            end
          end else begin
            for (int k = 0; k < TAIL_WORDS; k++) begin
              if (cand_nxt[k] && (cnt_nxt >= tail_len(k) || tail_char(k, cnt_nxt) != b))
                cand_nxt[k] = 1'b0;
            end
            if (cnt_nxt != 4'd15) cnt_nxt = cnt_nxt + 4'd1;
            if (cand_nxt == 7'd0) begin
              fail_nxt = 1'b1; adv = 1'b0;
            end else if (cand_nxt[SOURCE_WORD] && cnt_nxt == tail_len(SOURCE_WORD)) begin
              ph_nxt = PH_INDEX; idx_nxt = 8'd0; dig_nxt = 1'b0;
            end
          end
        end
        PH_INDEX: begin
          if (b == "/") begin
            if (!dig_nxt || idx_nxt < 8'd1 || idx_nxt > MAXS) begin
              fail_nxt = 1'b1; adv = 1'b0;
            end else begin
              ph_nxt = PH_LEAF; cnt_nxt = 4'd0; cand_nxt = 7'h0F;
            end
          end else if (b >= "0" && b <= "9") begin
            dig_nxt = 1'b1;
            idx_mul = {3'd0, idx_nxt} * 11'd10 + {3'd0, b - 8'h30};
            idx_nxt = (idx_mul > {3'd0, SAT}) ? SAT : idx_mul[7:0];
          end else begin
            fail_nxt = 1'b1; adv = 1'b0;
          end
        end
        PH_LEAF: begin
          if (b == 8'd0) begin
            for (int k = LEAF_WORDS - 1; k >= 0; k--) begin
              if (cand_nxt[k] && leaf_len(k) == cnt_nxt) begin
                found = 1'b1; k_found = 4'(k);
              end
            end
            if (!found) begin
              fail_nxt = 1'b1; adv = 1'b0;
            end else begin
              code_nxt = 4'd6 + k_found; ph_nxt = PH_APAD;
            end
          end else begin
            for (int k = 0; k < LEAF_WORDS; k++) begin
              if (cand_nxt[k] && (cnt_nxt >= leaf_len(k) || leaf_char(k, cnt_nxt) != b))
                cand_nxt[k] = 1'b0;
            end
            if (cnt_nxt != 4'd15) cnt_nxt = cnt_nxt + 4'd1;
            if (cand_nxt == 7'd0) begin
              fail_nxt = 1'b1; adv = 1'b0;
            end
          end
        end
        PH_TAG: begin
          if (cnt_nxt == 4'd0) begin
            if (b != ",") begin
              fail_nxt = 1'b1; adv = 1'b0;
            end
          end else if (cnt_nxt == 4'd1) begin
            if (b == "f") tl_nxt = TL_F;
            else if (b == "i") tl_nxt = TL_I;
            else begin
              fail_nxt = 1'b1; adv = 1'b0;
            end
          end else if (b == 8'd0) ph_nxt = PH_TPAD;
          if (adv && cnt_nxt != 4'd15) cnt_nxt = cnt_nxt + 4'd1;
        end
        PH_ARG: begin
          arg_nxt = {arg_nxt[23:0], b};
          if (cnt_nxt != 4'd15) cnt_nxt = cnt_nxt + 4'd1;
          if (cnt_nxt >= 4'd4) ph_nxt = PH_DONE;
        end
        default: ;
      endcase
      if (adv) begin
        align_nxt = align_r + 2'd1;
        if (align_nxt == 2'd0) begin
          if (ph_nxt == PH_APAD) begin
            ph_nxt = PH_TAG; cnt_nxt = 4'd0;
          end else if (ph_nxt == PH_TPAD) begin
            ph_nxt = PH_ARG; cnt_nxt = 4'd0; arg_nxt = 32'd0;
          end
        end
      end
    end
  end

  osmp_i2f u_i2f (.raw(arg_nxt), .single(conv));

  assign last = take && in_last_byte;
  assign ok   = !fail_nxt && ph_nxt == PH_DONE;

  always_ff @(posedge clk) begin
    if (!rst_n || last) begin
      ph_r <= PH_PREFIX; cnt_r <= 4'd0; cand_r <= 7'h7F; idx_r <= 8'd0;
      dig_r <= 1'b0; tl_r <= TL_NONE; arg_r <= 32'd0; fail_r <= 1'b0;
      align_r <= 2'd0; code_r <= 4'd0;
    end else if (take) begin
      ph_r <= ph_nxt; cnt_r <= cnt_nxt; cand_r <= cand_nxt; idx_r <= idx_nxt;
      dig_r <= dig_nxt; tl_r <= tl_nxt; arg_r <= arg_nxt; fail_r <= fail_nxt;
      align_r <= align_nxt; code_r <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (last) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (last) begin
      oa_r  <= ok;
      oc_r  <= ok ? code_nxt : 4'd0;
      os_r  <= (ok && code_nxt >= 4'd6) ? idx_nxt[6:0] : 7'd0;
      ovb_r <= ok ? ((tl_nxt == TL_I) ? conv : arg_nxt) : 32'd0;
    end
  end

  assign out_valid          = ov_r;
  assign out_accepted       = oa_r;
  assign out_parameter_code = oc_r;
  assign out_source_number  = os_r;
  assign out_value_bits     = ovb_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(ovb_r)) else $error("result lost");
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !oa_r |-> oc_r == 4'd0 && os_r == 7'd0) else $error("reject not zero");
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oa_r && oc_r >= 4'd6 |-> os_r >= 7'd1 && {1'b0, os_r} <= MAXS)
    else $error("bad source");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |-> !in_ready) else $error("overrun");
endmodule

/* rtl/osmp_i2f.sv */
module osmp_i2f (
  input  logic [31:0] raw,
  output logic [31:0] single
);
  logic        sgn;
  logic [31:0] mag;
  logic [4:0]  e;
  logic [31:0] norm;
  logic [23:0] mant;
  logic [25:0] mant_r;
  logic        rnd;
  logic [7:0]  expo;

  always_comb begin
    sgn  = raw[31];
    mag  = sgn ? (32'd0 - raw) : raw;
    e    = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) e = 5'(i);
    end
    norm = mag << (5'd31 - e);
    mant = norm[31:8];
    rnd  = norm[7] && (norm[6:0] != 7'd0 || norm[8]);
    mant_r = {2'b0, mant} + {25'd0, rnd};
    expo = 8'd127 + {3'd0, e};
    if (mant_r[24]) begin
      expo = expo + 8'd1;
    end
    if (raw == 32'd0) single = 32'd0;
    else single = {sgn, expo, mant_r[24] ? 23'd0 : mant_r[22:0]};
  end
endmodule

/* tb/osc_source_message_parser_unit_checker.sv */
`timescale 1ns / 100ps
module osc_source_message_parser_unit_checker (
  input  logic   clk,
  input  logic   rst_n,
  osmp_stream_if in_ch,
  osmp_stream_if out_ch,
  osmp_stream_if cfg_ch,
  output int     errors,
  output int     pending
);
  import osmp_pkg::*;

  typedef struct packed {
    logic        accepted;
    logic [3:0]  code;
    logic [6:0]  source;
    logic [31:0] value;
  } osc_result_t;

  string tail_words[7] = '{"linked", string'(KW_ACTIVE), "azimuth", "elevation", "width",
                           "size", "source/"};
  string leaf_words[4] = '{"azimuth", "elevation", "size", "meter"};

  logic [63:0] prefix_chars;
  logic [3:0]  prefix_len;
  phase_t      phase;
  logic [3:0]  pos;
  logic [6:0]  live_words;
  int          src_index;
  bit          got_digit;
  logic [1:0]  type_tag;
  logic [31:0] arg_word;
  bit          dead;
  logic [1:0]  word_align;
  logic [3:0]  code_held;
  osc_result_t expected_results[$];

  function automatic logic [31:0] int_to_single(input logic [31:0] raw);
    logic [31:0] mag, mant, rem, half;
    int e, s;
    logic sgn;
    if (raw == 0) return 32'd0;
    sgn = raw[31];
    mag = sgn ? -raw : raw;
    e = 31;
    while (!mag[e]) e--;
    if (e <= 23) begin
      mant = mag << (23 - e);
    end else begin
      s = e - 23;
      rem = mag & ((32'd1 << s) - 1);
      half = 32'd1 << (s - 1);
      mant = mag >> s;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == 32'h0100_0000) begin
        mant = mant >> 1;
        e++;
      end
    end
    return {sgn, 8'(e + 127), mant[22:0]};
  endfunction

  task automatic clear_parse();
    phase = PH_PREFIX;
    pos = 0;
    live_words = 7'h7f;
    src_index = 0;
    got_digit = 0;
    type_tag = TL_NONE;
    arg_word = 0;
    dead = 0;
    word_align = 0;
    code_held = 0;
  endtask

  task automatic bump();
    if (pos != 4'd15) pos++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int eff, k, found;
    eff = (prefix_len > 8) ? 8 : prefix_len;
    found = -1;
    if (phase == PH_PREFIX && pos >= eff) begin
      phase = PH_TAIL;
      pos = 0;
      live_words = 7'h7f;
    end
    case (phase)
      PH_PREFIX: begin
        if (b != prefix_chars[56 - 8 * pos +: 8]) begin
          dead = 1;
          return;
        end
        bump();
      end
      PH_TAIL: begin
        if (b == 0) begin
          for (k = 0; k < SOURCE_WORD; k++)
            if (found < 0 && live_words[k] && tail_words[k].len() == pos) found = k;
          if (found < 0) begin
            dead = 1;
            return;
          end
          code_held = 4'(found);
          src_index = 0;
          phase = PH_APAD;
        end else begin
          for (k = 0; k < TAIL_WORDS; k++)
            if (live_words[k] && (pos >= tail_words[k].len() || tail_words[k][pos] != b))
              live_words[k] = 0;
          bump();
          if (live_words == 0) begin
            dead = 1;
            return;
          end
          if (live_words[SOURCE_WORD] && pos == 7) begin
            phase = PH_INDEX;
            src_index = 0;
            got_digit = 0;
          end
        end
      end
      PH_INDEX: begin
        if (b == "/") begin
          if (!got_digit || src_index < 1 || src_index > 64) begin
            dead = 1;
            return;
          end
          phase = PH_LEAF;
          pos = 0;
          live_words = 7'h0f;
        end else if (b >= "0" && b <= "9") begin
          got_digit = 1;
          src_index = src_index * 10 + (b - "0");
          if (src_index > 65) src_index = 65;
        end else begin
          dead = 1;
          return;
        end
      end
      PH_LEAF: begin
        if (b == 0) begin
          for (k = 0; k < LEAF_WORDS; k++)
            if (found < 0 && live_words[k] && leaf_words[k].len() == pos) found = k;
          if (found < 0) begin
            dead = 1;
            return;
          end
          code_held = 4'(6 + found);
          phase = PH_APAD;
        end else begin
          for (k = 0; k < LEAF_WORDS; k++)
            if (live_words[k] && (pos >= leaf_words[k].len() || leaf_words[k][pos] != b))
              live_words[k] = 0;
          bump();
          if (live_words == 0) begin
            dead = 1;
            return;
          end
        end
      end
      PH_TAG: begin
        if (pos == 0) begin
          if (b != ",") begin
            dead = 1;
            return;
          end
        end else if (pos == 1) begin
          if (b == "f") type_tag = TL_F;
          else if (b == "i") type_tag = TL_I;
          else begin
            dead = 1;
            return;
          end
        end else if (b == 0) begin
          phase = PH_TPAD;
        end
        bump();
      end
      PH_ARG: begin
        arg_word = {arg_word[23:0], b};
        bump();
        if (pos >= 4) phase = PH_DONE;
      end
      default: ;
    endcase
    word_align++;
    if (word_align == 0) begin
      if (phase == PH_APAD) begin
        phase = PH_TAG;
        pos = 0;
      end else if (phase == PH_TPAD) begin
        phase = PH_ARG;
        pos = 0;
        arg_word = 0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    osc_result_t r, got;
    if (!rst_n) begin
      prefix_chars = 0;
      prefix_len = 0;
      clear_parse();
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.data[64] == CFG_PREFIX_BYTES) prefix_chars = cfg_ch.data[63:0];
        else prefix_len = cfg_ch.data[3:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        if (!dead) parse_byte(in_ch.data[7:0]);
        if (in_ch.data[8]) begin
          r = '0;
          if (!dead && phase == PH_DONE) begin
            r.accepted = 1;
            r.code = code_held;
            r.source = (code_held >= 6) ? 7'(src_index) : 7'd0;
            r.value = (type_tag == TL_I) ? int_to_single(arg_word) : arg_word;
          end
          expected_results.push_back(r);
          clear_parse();
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          errors++;
        end else begin
          r = expected_results.pop_front();
          check_field("accepted", 32'(r.accepted), 32'(got.accepted));
          check_field("parameter_code", 32'(r.code), 32'(got.code));
          check_field("source_number", 32'(r.source), 32'(got.source));
          check_field("value_bits", r.value, got.value);
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule

/* tb/osc_source_message_parser_unit_tb.sv */
`timescale 1ns / 100ps
module osc_source_message_parser_unit_tb;
  import osmp_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  int   errors, pending;
  int   gap_max = 0;
  bit   out_stall = 0;
  logic [63:0] cur_prefix = 0;
  logic [3:0]  cur_len = 0;
  logic [7:0]  dgram[$];

  osmp_stream_if #(9)  in_ch();
  osmp_stream_if #(44) out_ch();
  osmp_stream_if #(65) cfg_ch();

  osc_source_message_parser_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data_byte(in_ch.data[7:0]), .in_last_byte(in_ch.data[8]),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_accepted(out_ch.data[43]), .out_parameter_code(out_ch.data[42:39]),
    .out_source_number(out_ch.data[38:32]), .out_value_bits(out_ch.data[31:0]),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.data[64]), .cfg_wdata(cfg_ch.data[63:0])
  );

  osc_source_message_parser_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int n;
    out_ch.ready = 0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) out_stall = !out_stall;
      n = out_stall ? $urandom_range(0, 17) : 0;
      if (n > 0) begin
        out_ch.ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(negedge clk);
      while (!out_ch.valid) @(negedge clk);
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int g;
    g = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= {last, b};
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) dgram.push_back(s[i]);
  endtask

  task automatic pad_word();
    dgram.push_back(8'h00);
    while (dgram.size() % 4 != 0) dgram.push_back(8'($urandom));
  endtask

  task automatic build(input string tail, input string tag, input logic [31:0] arg,
                       input int extra);
    int eff;
    eff = (cur_len > 8) ? 8 : cur_len;
    dgram.delete();
    for (int i = 0; i < eff; i++) dgram.push_back(cur_prefix[56 - 8 * i +: 8]);
    push_text(tail);
    pad_word();
    push_text(tag);
    pad_word();
    for (int i = 3; i >= 0; i--) dgram.push_back(arg[8 * i +: 8]);
    repeat (extra) dgram.push_back(8'($urandom));
  endtask

  task automatic send_dgram(input int cut);
    int n;
    n = (cut > 0 && cut < dgram.size()) ? cut : dgram.size();
    for (int i = 0; i < n; i++) send_byte(dgram[i], i == n - 1);
  endtask

  task automatic settle();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.data <= {idx, v};
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    if (idx == CFG_PREFIX_BYTES) cur_prefix = v;
    else cur_len = v[3:0];
  endtask

  function automatic string pick_tail();
    string globals[6] = '{"linked", string'(KW_ACTIVE), "azimuth", "elevation", "width",
                          "size"};
    string leaves[4] = '{"azimuth", "elevation", "size", "meter"};
    string idx;
    int r;
    r = $urandom_range(0, 19);
    if (r < 7) return globals[$urandom_range(0, 5)];
    if (r == 19) return "sourc";
    case ($urandom_range(0, 9))
      0: idx = "0";
      1: idx = "65";
      2: idx = $sformatf("%0d", $urandom_range(100, 99999));
      3: idx = "";
      4: idx = "1x";
      5: idx = $sformatf("00%0d", $urandom_range(1, 64));
      default: idx = $sformatf("%0d", $urandom_range(1, 64));
    endcase
    if ($urandom_range(0, 9) == 0) return {"source/", idx, "/", "width"};
    return {"source/", idx, "/", leaves[$urandom_range(0, 3)]};
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return 32'h0100_0001;
      5: return 32'h0100_0003;
      6: return 32'h00ff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_message();
    string tag;
    int r, cut;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      dgram.delete();
      repeat ($urandom_range(1, 20)) dgram.push_back(8'($urandom));
      send_dgram(0);
      return;
    end
    case ($urandom_range(0, 11))
      0: tag = ",";
      1: tag = ",q";
      2: tag = {",f", "ab"};
      3: tag = "xi";
      4, 5, 6, 7: tag = ",i";
      default: tag = ",f";
    endcase
    build(pick_tail(), tag, pick_arg(), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0);
    if ($urandom_range(0, 9) == 0) dgram[$urandom_range(0, dgram.size() - 1)] = 8'($urandom);
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, dgram.size() - 1) : 0;
    send_dgram(cut);
  endtask

  initial begin
    logic [63:0] prefixes[7];
    logic [3:0]  lengths[7];
    in_ch.valid = 0;
    in_ch.data = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    build("linked", ",f", 32'h3f80_0000, 0);          send_dgram(0);
    build(string'(KW_ACTIVE), ",i", 32'h0000_0040, 0); send_dgram(0);
    build("azimuth", ",i", 32'hffff_ffff, 0);         send_dgram(0);
    build("elevation", ",i", 32'h8000_0000, 0);       send_dgram(0);
    build("width", ",i", 32'h7fff_ffff, 0);           send_dgram(0);
    build("size", ",i", 32'h0100_0003, 3);            send_dgram(0);
    build("source/1/azimuth", ",f", 32'hffff_ffff, 0); send_dgram(0);
    build("source/64/elevation", ",i", 0, 0);         send_dgram(0);
    build("source/007/size", ",i", 32'h0100_0001, 0); send_dgram(0);
    build("source/12/meter", ",fxyz", 32'h4049_0fdb, 0); send_dgram(0);
    build("source/0/size", ",f", 1, 0);              send_dgram(0);
    build("source/65/size", ",f", 1, 0);             send_dgram(0);
    build("source/99999999/meter", ",f", 1, 0);      send_dgram(0);
    build("source//size", ",f", 1, 0);               send_dgram(0);
    build("source/3a/size", ",f", 1, 0);             send_dgram(0);
    build("source/3/width", ",f", 1, 0);             send_dgram(0);
    build("size", ",", 1, 0);                        send_dgram(0);
    build("size", ",x", 1, 0);                       send_dgram(0);
    build("size", ",f", 1, 0);                       send_dgram(dgram.size() - 2);
    build("linke", ",f", 1, 0);                      send_dgram(0);
    build("", ",f", 1, 0);                           send_dgram(0);
    settle();

    prefixes[0] = "/osc/mix"; lengths[0] = 8;
    prefixes[1] = "/osc/mix"; lengths[1] = 3;
    prefixes[2] = 64'hffff_ffff_ffff_ffff; lengths[2] = 15;
    prefixes[3] = {$urandom, $urandom} | 64'h0101_0101_0101_0101; lengths[3] = 5;
    prefixes[4] = "/ab\000cdef"; lengths[4] = 6;
    prefixes[5] = {$urandom, $urandom} | 64'h0101_0101_0101_0101; lengths[5] = 1;
    prefixes[6] = 64'h0; lengths[6] = 0;
    for (int p = 0; p < 7; p++) begin
      write_reg(CFG_PREFIX_BYTES, prefixes[p]);
      write_reg(CFG_PREFIX_LENGTH, 64'(lengths[p]));
      cfg_ch.valid <= 0;
      for (int m = 0; m < 2; m++) begin
        gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
        random_message();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
